// ----- sv/vpv_pkg.sv -----
package vpv_pkg;

    localparam int WORD_W = 32;
    localparam int SUM_W  = 66;

    typedef enum logic [1:0] {
        OP_LOAD_MV   = 2'd0,
        OP_LOAD_PROJ = 2'd1,
        OP_PROJECT   = 2'd2
    } opcode_t;

    localparam logic [1:0] CFG_VIEWPORT_X      = 2'd0;
    localparam logic [1:0] CFG_VIEWPORT_Y      = 2'd1;
    localparam logic [1:0] CFG_VIEWPORT_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_VIEWPORT_HEIGHT = 2'd3;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -66'sh0_8000_0000;

    // side data traveling with the divider lanes
    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } div_tag_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[WORD_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ----- sv/vpv_if.sv -----
interface vpv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [3:0]         slot;
    logic signed [31:0] coefficient;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, opcode, slot, coefficient, point_x, point_y, point_z,
                    input ready);
    modport sink   (input valid, opcode, slot, coefficient, point_x, point_y, point_z,
                    output ready);
endinterface

interface vpv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               ok;

    modport source (output valid, screen_x, screen_y, depth, ok, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, ok, output ready);
endinterface

// ----- sv/vpv_div3.sv -----
// Three restoring dividers sharing one divisor, one quotient bit per stage.
module vpv_div3 #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  vpv_pkg::div_tag_t   in_tag,
    input  logic [NW-1:0]       in_num [3],
    input  logic [DW-1:0]       in_den,
    output logic                out_valid,
    output vpv_pkg::div_tag_t   out_tag,
    output logic [NW-1:0]       out_quo [3]
);
    import vpv_pkg::*;

    logic          vld_reg [NW+1];
    div_tag_t      tag_reg [NW+1];
    logic [DW-1:0] den_reg [NW+1];
    logic [NW-1:0] nq_reg  [NW+1][3];
    logic [DW-1:0] rem_reg [NW+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
            begin
                vld_reg[k] <= 1'b0;
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < NW; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= in_den;
            for (int l = 0; l < 3; l++)
            begin
                nq_reg[0][l]  <= in_num[l];
                rem_reg[0][l] <= '0;
            end
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [NW-1:0] nq_next;

            always_comb
            begin
                trial    = {rem_reg[k][l], nq_reg[k][l][NW-1]};
                diff     = trial - {1'b0, den_reg[k]};
                ge       = trial >= {1'b0, den_reg[k]};
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                nq_next  = {nq_reg[k][l][NW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][l] <= rem_next;
                    nq_reg[k+1][l]  <= nq_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                den_reg[k+1] <= den_reg[k];
        end
    end

    assign out_valid = vld_reg[NW];
    assign out_tag   = tag_reg[NW];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign out_quo[l] = nq_reg[NW][l];
    end

endmodule

// ----- sv/vertex_project_to_viewport.sv -----
// Channel   Dir  Payload                                      Transaction when
// in_ch     in   opcode, slot, coefficient, point_x/y/z       valid && ready
// out_ch    out  screen_x, screen_y, depth, ok                valid && ready
// cfg       in   cfg_index, cfg_data                          cfg_we
//
// One transaction per cycle in unless the output stalls; fixed point is Q16.16 at the
// default FRAC_BITS, and the divider resolves one quotient bit per stage.
// Reset clears both matrices and loads the viewport defaults (0, 0, 1024, 768).
// A stall at the output holds every stage in place; in_ch.ready is low only while
// a finished result waits and out_ch.ready is low.
module vertex_project_to_viewport #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    vpv_in_if.sink      in_ch,
    vpv_out_if.source   out_ch
);
    import vpv_pkg::*;

    localparam int NW = WORD_W + FRAC_BITS;   // dividend magnitude bits
    localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;

    // pipeline advance: the output register is free or is being taken
    logic en;
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- configuration ----------------
    logic signed [15:0] vx_reg, vy_reg;
    logic [14:0]        vw_reg, vh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
            vw_reg <= 15'd1024;
            vh_reg <= 15'd768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VIEWPORT_X:      vx_reg <= cfg_data;
                CFG_VIEWPORT_Y:      vy_reg <= cfg_data;
                CFG_VIEWPORT_WIDTH:  vw_reg <= cfg_data[14:0];
                CFG_VIEWPORT_HEIGHT: vh_reg <= cfg_data[14:0];
            endcase
        end
    end

    // ---------------- matrices ----------------
    // Model-view is written at accept, projection when the load reaches stage 3,
    // the two points where the entries are read, so order is kept.
    logic signed [31:0] mv_reg [16];
    logic signed [31:0] pj_reg [16];

    logic        in_take;
    assign in_take = en && in_ch.valid;

    logic               s2_vld_reg;
    logic [1:0]         s2_op_reg;
    logic [3:0]         s2_slot_reg;
    logic signed [31:0] s2_coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mv_reg[i] <= '0;
                pj_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_take && in_ch.opcode == OP_LOAD_MV)
                mv_reg[in_ch.slot] <= in_ch.coefficient;
            if (en && s2_vld_reg && s2_op_reg == OP_LOAD_PROJ)
                pj_reg[s2_slot_reg] <= s2_coef_reg;
        end
    end

    // ---------------- stage 1: model-view products ----------------
    logic               s1_vld_reg;
    logic [1:0]         s1_op_reg;
    logic [3:0]         s1_slot_reg;
    logic signed [31:0] s1_coef_reg;
    logic signed [63:0] s1_prod_reg  [4][3];
    logic signed [31:0] s1_trans_reg [4];
    logic signed [31:0] pt [3];

    assign pt[0] = in_ch.point_x;
    assign pt[1] = in_ch.point_y;
    assign pt[2] = in_ch.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= in_ch.opcode;
            s1_slot_reg <= in_ch.slot;
            s1_coef_reg <= in_ch.coefficient;
            for (int r = 0; r < 4; r++)
            begin
                s1_trans_reg[r] <= mv_reg[12 + r];
                for (int j = 0; j < 3; j++)
                    s1_prod_reg[r][j] <= mv_reg[r + 4 * j] * pt[j];
            end
        end
    end

    // ---------------- stage 2: eye coordinates ----------------
    logic signed [31:0] eye_next   [4];
    logic signed [31:0] s2_eye_reg [4];

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < 4; r++)
        begin
            acc = SUM_W'(s1_trans_reg[r]);
            for (int j = 0; j < 3; j++)
                acc = acc + (SUM_W'(s1_prod_reg[r][j]) >>> FRAC_BITS);
            eye_next[r] = sat32(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_coef_reg <= s1_coef_reg;
            for (int r = 0; r < 4; r++)
                s2_eye_reg[r] <= eye_next[r];
        end
    end

    // ---------------- stage 3: projection products ----------------
    logic               s3_vld_reg;
    logic signed [31:0] s3_eye2_reg;
    logic signed [63:0] s3_prod_reg [3][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg && s2_op_reg == OP_PROJECT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_eye2_reg <= s2_eye_reg[2];
            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 4; j++)
                    s3_prod_reg[r][j] <= pj_reg[r + 4 * j] * s2_eye_reg[j];
        end
    end

    // ---------------- stage 4: clip coordinates ----------------
    logic               s4_vld_reg;
    logic signed [31:0] s4_eye2_reg;
    logic signed [31:0] clip_next   [3];
    logic signed [31:0] s4_clip_reg [3];

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = '0;
            for (int j = 0; j < 4; j++)
                acc = acc + (SUM_W'(s3_prod_reg[r][j]) >>> FRAC_BITS);
            clip_next[r] = sat32(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_eye2_reg <= s3_eye2_reg;
            for (int r = 0; r < 3; r++)
                s4_clip_reg[r] <= clip_next[r];
        end
    end

    // ---------------- divide: clip * 2^F / (-eye_z), sign-magnitude ----------------
    logic [NW-1:0] div_num [3];
    logic [31:0]   div_den;
    div_tag_t      div_tag_in;
    logic          d_neg;     // divisor -eye_z is negative

    always_comb
    begin
        logic [31:0] mag;
        d_neg   = !s4_eye2_reg[31] && s4_eye2_reg != '0;
        div_den = s4_eye2_reg[31] ? 32'(-s4_eye2_reg) : 32'(s4_eye2_reg);
        div_tag_in.zero = s4_eye2_reg == '0;
        for (int l = 0; l < 3; l++)
        begin
            mag = s4_clip_reg[l][31] ? 32'(-s4_clip_reg[l]) : 32'(s4_clip_reg[l]);
            div_num[l] = {mag, {FRAC_BITS{1'b0}}};
            div_tag_in.neg[l] = s4_clip_reg[l][31] ^ d_neg;
        end
    end

    logic          dv_vld;
    div_tag_t      dv_tag;
    logic [NW-1:0] dv_quo [3];

    vpv_div3 #(
        .NW (NW),
        .DW (32)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_vld_reg),
        .in_tag    (div_tag_in),
        .in_num    (div_num),
        .in_den    (div_den),
        .out_valid (dv_vld),
        .out_tag   (dv_tag),
        .out_quo   (dv_quo)
    );

    // ---------------- X1: signed, saturated ndc ----------------
    logic signed [31:0] ndc_next    [3];
    logic signed [31:0] x1_ndc_reg  [3];
    logic               x1_vld_reg;
    logic               x1_zero_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dv_tag.neg[l])
                ndc_next[l] = (dv_quo[l] > NW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                                 : 32'(-dv_quo[l]);
            else
                ndc_next[l] = (dv_quo[l] > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : dv_quo[l][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x1_vld_reg <= 1'b0;
        else if (en)
            x1_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_zero_reg <= dv_tag.zero;
            for (int l = 0; l < 3; l++)
                x1_ndc_reg[l] <= ndc_next[l];
        end
    end

    // ---------------- X2: viewport scale ----------------
    logic               x2_vld_reg;
    logic               x2_zero_reg;
    logic signed [48:0] x2_px_reg, x2_py_reg;
    logic signed [31:0] x2_dz_reg;
    logic signed [32:0] ax, ay, az;

    always_comb
    begin
        ax = 33'(x1_ndc_reg[0]) + ONE33;
        ay = 33'(x1_ndc_reg[1]) + ONE33;
        az = 33'(x1_ndc_reg[2]) + ONE33;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x2_vld_reg <= 1'b0;
        else if (en)
            x2_vld_reg <= x1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_zero_reg <= x1_zero_reg;
            x2_px_reg   <= ax * $signed({1'b0, vw_reg});
            x2_py_reg   <= ay * $signed({1'b0, vh_reg});
            x2_dz_reg   <= 32'(az >>> 1);   // (1 + ndc_z) / 2 always fits
        end
    end

    // ---------------- X3: offset, saturate, output register ----------------
    logic signed [SUM_W-1:0] sx_sum, sy_sum;
    logic                    out_vld_reg;
    logic signed [31:0]      out_sx_reg, out_sy_reg, out_dz_reg;
    logic                    out_ok_reg;

    always_comb
    begin
        sx_sum = (SUM_W'(x2_px_reg) >>> 1) + (SUM_W'(vx_reg) <<< FRAC_BITS);
        sy_sum = (SUM_W'(x2_py_reg) >>> 1) + (SUM_W'(vy_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= x2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // zero divisor: failed result with cleared fields
            out_ok_reg <= !x2_zero_reg;
            out_sx_reg <= x2_zero_reg ? '0 : sat32(sx_sum);
            out_sy_reg <= x2_zero_reg ? '0 : sat32(sy_sum);
            out_dz_reg <= x2_zero_reg ? '0 : x2_dz_reg;
        end
    end

    assign out_ch.valid    = out_vld_reg;
    assign out_ch.screen_x = out_sx_reg;
    assign out_ch.screen_y = out_sy_reg;
    assign out_ch.depth    = out_dz_reg;
    assign out_ch.ok       = out_ok_reg;

endmodule

// ----- sv/vpv_checker.sv -----
module vpv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] screen_x,
    input logic [31:0] screen_y,
    input logic [31:0] depth,
    input logic        ok
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(screen_x) && $stable(screen_y)
                                    && $stable(depth) && $stable(ok))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> screen_x == '0 && screen_y == '0 && depth == '0)
        else $error("failed projection with nonzero fields");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output");

endmodule

bind vertex_project_to_viewport vpv_checker u_vpv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .screen_x  (out_ch.screen_x),
    .screen_y  (out_ch.screen_y),
    .depth     (out_ch.depth),
    .ok        (out_ch.ok)
);
